// ===== rtl/crq_pkg.sv =====
`timescale 1ns / 1ps

package crq_pkg;

    // Field widths of one queued request
    localparam int TAG_W   = 16;
    localparam int FRAME_W = 32;
    localparam int PAY_W   = 32;
    localparam int CNT_W   = 32;

    // Request kinds (the unused fourth code behaves as a pop)
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_APPENDED = 3'd0;
    localparam logic [2:0] STAT_REPLACED = 3'd1;
    localparam logic [2:0] STAT_DROPPED  = 3'd2;
    localparam logic [2:0] STAT_POPPED   = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;
    localparam logic [2:0] STAT_RESET    = 3'd5;

    // One queue slot
    typedef struct packed {
        logic               has_clip;
        logic [TAG_W-1:0]   clip_tag;
        logic [FRAME_W-1:0] target_frame;
        logic [PAY_W-1:0]   payload;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One incoming request
    typedef struct packed {
        logic [1:0] req_type;
        t_entry     entry;
    } t_req;

    // Per-request result apart from depth and running totals
    typedef struct packed {
        logic [2:0] status;
        t_entry     entry;
    } t_result;

endpackage

// ===== rtl/crq_ram.sv =====
`timescale 1ns / 1ps

module crq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/crq_engine.sv =====
`timescale 1ns / 1ps

module crq_engine #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  crq_pkg::t_req                   i_req,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output crq_pkg::t_result                o_res,
    output logic [$clog2(SLOT_COUNT+1)-1:0] o_depth,
    output logic [crq_pkg::CNT_W-1:0]       o_submitted,
    output logic [crq_pkg::CNT_W-1:0]       o_dropped
);

    import crq_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int DW = $clog2(SLOT_COUNT + 1);

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);
    localparam logic [DW-1:0] FULL_CNT  = DW'(SLOT_COUNT);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_APPEND = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [DW-1:0]    r_count, n_count;
    logic [DW-1:0]    r_k, n_k;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_submit, n_submit;
    logic [CNT_W-1:0] r_drop, n_drop;
    t_req             r_req, n_req;
    logic [2:0]       r_status, n_status;
    t_entry           r_entry, n_entry;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    logic                hit;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    crq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.entry),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = ram_rdata;

    // Key compare on the slot read in the previous scan cycle
    assign hit = r_pend && rd_entry.has_clip
              && (rd_entry.clip_tag == r_req.entry.clip_tag)
              && (rd_entry.target_frame == r_req.entry.target_frame);

    // Scan walks newest first; otherwise the head is kept on the read port
    assign ram_raddr = (r_state == ST_SCAN) ? r_ptr : r_head;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_ptr    = r_ptr;
        n_paddr  = r_paddr;
        n_count  = r_count;
        n_k      = r_k;
        n_pend   = r_pend;
        n_submit = r_submit;
        n_drop   = r_drop;
        n_req    = r_req;
        n_status = r_status;
        n_entry  = r_entry;
        ram_we    = 1'b0;
        ram_waddr = r_tail;

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_entry = '0;
                    case (i_req.req_type)
                        REQ_PUSH: begin
                            n_submit = r_submit + 1'b1;
                            if (i_req.entry.has_clip && (r_count != '0)) begin
                                n_ptr   = wrap_dec(r_tail);
                                n_k     = '0;
                                n_pend  = 1'b0;
                                n_state = ST_SCAN;
                            end else begin
                                n_state = ST_APPEND;
                            end
                        end
                        REQ_RESET: begin
                            n_drop   = r_drop + CNT_W'(r_count);
                            n_count  = '0;
                            n_tail   = r_head;
                            n_status = STAT_RESET;
                            n_state  = ST_DONE;
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_POP;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    // overwrite in place; key fields are identical
                    ram_we    = 1'b1;
                    ram_waddr = r_paddr;
                    n_status  = STAT_REPLACED;
                    n_state   = ST_DONE;
                end else if (r_k == r_count) begin
                    n_state = ST_APPEND;
                end else begin
                    n_paddr = r_ptr;
                    n_ptr   = wrap_dec(r_ptr);
                    n_k     = r_k + 1'b1;
                    n_pend  = 1'b1;
                end
            end
            ST_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail;
                n_tail    = wrap_inc(r_tail);
                if (r_count == FULL_CNT) begin
                    // full: oldest goes, count stays
                    n_head   = wrap_inc(r_head);
                    n_drop   = r_drop + 1'b1;
                    n_status = STAT_DROPPED;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = STAT_APPENDED;
                end
                n_state = ST_DONE;
            end
            ST_POP: begin
                n_entry  = rd_entry;
                n_head   = wrap_inc(r_head);
                n_count  = r_count - 1'b1;
                n_status = STAT_POPPED;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_submit <= '0;
            r_drop   <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_submit <= n_submit;
            r_drop   <= n_drop;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_paddr  <= n_paddr;
        r_k      <= n_k;
        r_pend   <= n_pend;
        r_req    <= n_req;
        r_status <= n_status;
        r_entry  <= n_entry;
    end

    assign o_req_ready  = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_DONE);
    assign o_res.status = r_status;
    assign o_res.entry  = r_entry;
    assign o_depth      = r_count;
    assign o_submitted  = r_submit;
    assign o_dropped    = r_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_count == '0) |-> (r_tail == r_head))
        else $error("empty queue with head and tail apart");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_SCAN || r_state == ST_APPEND))
        else $error("slot write outside scan or append");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_k <= r_count))
        else $error("scan ran past the queued entries");

    a_submit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_req_valid && i_req.req_type == REQ_PUSH)
        |=> (r_submit == $past(r_submit) + 1'b1))
        else $error("push not counted");
`endif

endmodule

// ===== rtl/coalescing_request_queue_top.sv =====
`timescale 1ns / 1ps
// Coalescing request queue.
// Requests enter on the s_axis channel: tuser carries the request kind and the
// clip flag, tdata carries clip tag, target frame and payload. One result per
// request leaves on the m_axis channel: tuser carries the status and the
// popped clip flag, tdata the popped entry, the depth and the running submit
// and drop totals.
// A reset or an empty pop goes straight to the result state; a pop, or a push
// without clip tag or into an empty queue, passes a pop or append step first,
// and a push with clip tag over queued entries first runs the newest-first key
// scan, one slot per cycle through the single read port of the slot memory,
// and then replaces on a hit or appends. s_axis_tready is high only while the
// sequencer is idle, so one request is in work at a time; the next one may be
// taken while a finished result still sits in the output register.
// If m_axis stalls, the result holds in the output register and the next
// result waits in the sequencer until the register frees.
// Reset empties the queue and clears the totals; slot contents are not
// cleared, so no clearing pass is needed and the block is ready at once.

module coalescing_request_queue_top #(
    parameter int SLOT_COUNT = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // clip_tag[15:0], target_frame[47:16], payload[79:48]
    input  logic [79:0]  s_axis_tdata,
    // req_type[1:0], has_clip[2]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_clip_tag[15:0], out_target_frame[47:16], out_payload[79:48],
    // depth, submitted_total, dropped_total above, zero padded to bytes
    output logic [((144 + $clog2(SLOT_COUNT+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status[2:0], out_has_clip[3]
    output logic [3:0]   m_axis_tuser
);

    import crq_pkg::*;

    localparam int DW       = $clog2(SLOT_COUNT + 1);
    localparam int OUT_BITS = TAG_W + FRAME_W + PAY_W + DW + 2 * CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    t_req             req;
    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic [DW-1:0]    depth;
    logic [CNT_W-1:0] submitted;
    logic [CNT_W-1:0] dropped;

    logic             r_m_valid;
    logic [3:0]       r_m_user;
    logic [OUT_W-1:0] r_m_data;

    // Unpack request; a request without clip flag carries tag zero
    assign req.req_type           = s_axis_tuser[1:0];
    assign req.entry.has_clip     = s_axis_tuser[2];
    assign req.entry.clip_tag     = s_axis_tuser[2] ? s_axis_tdata[15:0] : '0;
    assign req.entry.target_frame = s_axis_tdata[47:16];
    assign req.entry.payload      = s_axis_tdata[79:48];

    crq_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_depth     (depth),
        .o_submitted (submitted),
        .o_dropped   (dropped)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_user <= {res.entry.has_clip, res.status};
            r_m_data <= OUT_W'({dropped, submitted, depth, res.entry.payload,
                                res.entry.target_frame, res.entry.clip_tag});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== tb/sv/coalescing_request_queue_top_test.sv =====
`timescale 1ns / 1ps

module coalescing_request_queue_top_test;

    import crq_pkg::*;

    localparam int QDEPTH  = 256;
    localparam int DEPTH_W = $clog2(QDEPTH + 1);
    localparam int OUT_W   = ((144 + DEPTH_W + 7) / 8) * 8;

    // Spare request kind, handled by the block as a pop
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Request gaps and result back-pressure stop over the closing stretch
    localparam int CALM_AFTER = 1150;

    // Ring of outstanding expected results, and room for the directed table
    localparam int PEND_SLOTS = 16;
    localparam int STEP_SLOTS = 32;

    // Everything one result carries
    typedef struct packed {
        logic [2:0]         status;
        t_entry             entry;
        logic [DEPTH_W-1:0] depth;
        logic [CNT_W-1:0]   submitted;
        logic [CNT_W-1:0]   dropped;
    } t_crq_result;

    // One directed step, with the result typed in where it is obvious
    typedef struct packed {
        bit          known;
        logic [1:0]  kind;
        t_entry      req;
        t_crq_result res;
    } t_step_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // clip_tag[15:0], target_frame[47:16], payload[79:48]
    logic [79:0]      s_axis_tdata = '0;
    // req_type[1:0], has_clip[2]
    logic [2:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // out_clip_tag[15:0], out_target_frame[47:16], out_payload[79:48],
    // depth, submitted_total, dropped_total, zero padding
    logic [OUT_W-1:0] m_axis_tdata;
    // status[2:0], out_has_clip[3]
    logic [3:0]       m_axis_tuser;

    coalescing_request_queue_top #(
        .SLOT_COUNT(QDEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the queue
    t_entry           shadow_slot [QDEPTH];
    int               shadow_head = 0;
    int               shadow_count = 0;
    logic [CNT_W-1:0] shadow_submits = '0;
    logic [CNT_W-1:0] shadow_drops = '0;

    t_crq_result      pending_results [PEND_SLOTS];
    int               pend_wr = 0;
    int               pend_rd = 0;
    t_step_row        directed_steps [STEP_SLOTS];
    int               step_total = 0;
    t_crq_result      want;
    int               mismatch_count = 0;
    int               status_seen [8];
    bit               calm = 1'b0;
    int               stall_left = 0;

    // Next result of the queue for one accepted request; updates the shadow
    function automatic t_crq_result predict_queue_result(input logic [1:0] kind,
                                                         input t_entry req);
        t_crq_result r;
        t_entry      e;
        int          k;
        int          s;
        bit          hit;
        r = '0;
        e = req;
        if (!e.has_clip) e.clip_tag = '0;
        hit = 1'b0;
        case (kind)
            REQ_PUSH: begin
                shadow_submits = shadow_submits + 1'b1;
                // newest-first key scan, clip-tagged pushes only
                if (e.has_clip) begin
                    for (k = 0; k < shadow_count && !hit; k++) begin
                        s = (shadow_head + shadow_count - 1 - k) % QDEPTH;
                        if (shadow_slot[s].has_clip && shadow_slot[s].clip_tag == e.clip_tag
                                && shadow_slot[s].target_frame == e.target_frame) begin
                            shadow_slot[s].payload = e.payload;
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) begin
                    r.status = STAT_REPLACED;
                end else begin
                    r.status = STAT_APPENDED;
                    if (shadow_count >= QDEPTH) begin
                        shadow_head = (shadow_head + 1) % QDEPTH;
                        shadow_count--;
                        shadow_drops = shadow_drops + 1'b1;
                        r.status = STAT_DROPPED;
                    end
                    shadow_slot[(shadow_head + shadow_count) % QDEPTH] = e;
                    shadow_count++;
                end
            end
            REQ_RESET: begin
                shadow_drops = shadow_drops + CNT_W'(shadow_count);
                shadow_count = 0;
                r.status = STAT_RESET;
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.entry = shadow_slot[shadow_head];
                    shadow_head = (shadow_head + 1) % QDEPTH;
                    shadow_count--;
                    r.status = STAT_POPPED;
                end
            end
        endcase
        r.depth = shadow_count[DEPTH_W-1:0];
        r.submitted = shadow_submits;
        r.dropped = shadow_drops;
        return r;
    endfunction

    // Directed step; status and totals only meaningful when known is set
    task automatic add_step(input bit known, input logic [1:0] kind, input logic hc,
                            input logic [15:0] tag, input logic [31:0] frame,
                            input logic [31:0] pay, input logic [2:0] status,
                            input int depth, input logic [31:0] sub,
                            input logic [31:0] drop);
        t_step_row row;
        row = '0;
        row.known = known;
        row.kind = kind;
        row.req.has_clip = hc;
        row.req.clip_tag = tag;
        row.req.target_frame = frame;
        row.req.payload = pay;
        row.res.status = status;
        row.res.depth = depth[DEPTH_W-1:0];
        row.res.submitted = sub;
        row.res.dropped = drop;
        directed_steps[step_total] = row;
        step_total++;
    endtask

    // Offer one request, with an occasional gap first, and record its result
    task automatic issue_request(input logic [1:0] kind, input t_entry e, input bit known,
                                 input t_crq_result known_res);
        t_crq_result r;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {e.has_clip, kind};
        s_axis_tdata <= {e.payload, e.target_frame, e.clip_tag};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_queue_result(kind, e);
        if (known) r = known_res;
        status_seen[r.status]++;
        pending_results[pend_wr % PEND_SLOTS] = r;
        pend_wr++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Result side back-pressure in short bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pend_wr == pend_rd) begin
                $display("%0t: result with nothing outstanding, tuser %h tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results[pend_rd % PEND_SLOTS];
                pend_rd++;
                compare_field("status", 32'(want.status), 32'(m_axis_tuser[2:0]));
                compare_field("out_has_clip", 32'(want.entry.has_clip),
                              32'(m_axis_tuser[3]));
                compare_field("out_clip_tag", 32'(want.entry.clip_tag),
                              32'(m_axis_tdata[15:0]));
                compare_field("out_target_frame", want.entry.target_frame,
                              m_axis_tdata[47:16]);
                compare_field("out_payload", want.entry.payload, m_axis_tdata[79:48]);
                compare_field("depth", 32'(want.depth), 32'(m_axis_tdata[80 +: DEPTH_W]));
                compare_field("submitted_total", want.submitted,
                              m_axis_tdata[80 + DEPTH_W +: CNT_W]);
                compare_field("dropped_total", want.dropped,
                              m_axis_tdata[80 + DEPTH_W + CNT_W +: CNT_W]);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[coalescing_request_queue_top] ERROR");
        $finish;
    end

    initial begin
        int          seg;
        int          j;
        int          issued;
        int          seg_len;
        int          push_pct;
        int          reset_pct;
        int          pool_pct;
        int          roll;
        logic [1:0]  kind;
        t_entry      e;
        t_crq_result none;
        t_step_row   row;

        none = '0;
        foreach (status_seen[k]) status_seen[k] = 0;

        // Directed steps: empty queue, extreme keys, coalescing, reset drop count
        add_step(1, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000,
                 STAT_EMPTY, 0, 0, 0);
        add_step(1, REQ_SPARE, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 STAT_EMPTY, 0, 0, 0);
        add_step(1, REQ_RESET, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 STAT_RESET, 0, 0, 0);
        add_step(1, REQ_PUSH,  1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 STAT_APPENDED, 1, 1, 0);
        add_step(1, REQ_PUSH,  1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                 STAT_REPLACED, 1, 2, 0);
        add_step(1, REQ_PUSH,  0, 16'hFFFF, 32'hFFFF_FFFF, 32'h1234_5678,
                 STAT_APPENDED, 2, 3, 0);
        // tag zero must not match the untagged entry
        add_step(0, REQ_PUSH,  1, 16'h0000, 32'hFFFF_FFFF, 32'h0BAD_F00D, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'hFFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'h0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_SPARE, 0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_POP,   1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        // untagged pushes never coalesce
        add_step(0, REQ_PUSH,  0, 16'h1234, 32'h0000_0007, 32'h0000_0001, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  0, 16'h1234, 32'h0000_0007, 32'h0000_0002, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'h8000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
        add_step(0, REQ_RESET, 0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        // same tag, different frames; later push hits the older of the two
        add_step(0, REQ_PUSH,  1, 16'h0001, 32'h0000_0001, 32'h0000_0011, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'h0001, 32'h0000_0002, 32'h0000_0022, 0, 0, 0, 0);
        add_step(0, REQ_PUSH,  1, 16'h0001, 32'h0000_0001, 32'h0000_0033, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);
        add_step(0, REQ_POP,   0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (j = 0; j < step_total; j++) begin
            row = directed_steps[j];
            issue_request(row.kind, row.req, row.known, row.res);
        end

        // Random part in stretches of differing mix: push-heavy ones overflow the queue
        issued = 0;
        for (seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       begin seg_len = 150; push_pct = 50; reset_pct = 2; pool_pct = 40; end
                1:       begin seg_len = 350; push_pct = 97; reset_pct = 0; pool_pct = 10; end
                2:       begin seg_len = 120; push_pct = 60; reset_pct = 0; pool_pct = 50; end
                3:       begin seg_len = 200; push_pct = 25; reset_pct = 1; pool_pct = 30; end
                4:       begin seg_len = 300; push_pct = 90; reset_pct = 0; pool_pct = 15; end
                default: begin seg_len = 180; push_pct = 55; reset_pct = 2; pool_pct = 40; end
            endcase
            for (j = 0; j < seg_len; j++) begin
                calm = (issued >= CALM_AFTER);
                roll = $urandom_range(0, 99);
                if (roll < reset_pct)
                    kind = REQ_RESET;
                else if (roll < reset_pct + push_pct)
                    kind = REQ_PUSH;
                else
                    kind = ($urandom_range(0, 9) == 0) ? REQ_SPARE : REQ_POP;
                e.has_clip = ($urandom_range(0, 3) != 0);
                // small key pool makes coalescing hits likely
                if ($urandom_range(0, 99) < pool_pct) begin
                    e.clip_tag = 16'($urandom_range(0, 3));
                    e.target_frame = $urandom_range(0, 3);
                end else begin
                    e.clip_tag = 16'($urandom_range(0, 65535));
                    e.target_frame = $urandom;
                end
                e.payload = $urandom;
                issue_request(kind, e, 1'b0, none);
                issued++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pend_wr != pend_rd) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Requests: %0d appended, %0d coalesced, %0d appended over full queue",
                 status_seen[STAT_APPENDED], status_seen[STAT_REPLACED],
                 status_seen[STAT_DROPPED]);
        $display("          %0d popped, %0d empty pops, %0d queue resets",
                 status_seen[STAT_POPPED], status_seen[STAT_EMPTY], status_seen[STAT_RESET]);
        if (mismatch_count == 0) begin
            $display("[coalescing_request_queue_top] OK");
        end else begin
            $display("[coalescing_request_queue_top] ERROR");
        end
        $finish;
    end

endmodule
